// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent checks used in the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/pidpos_pkg.sv =====
// ----------------------------------------------------------------------------
// pidpos_pkg
// Types and constants shared by the position loop and its multiplier
// ----------------------------------------------------------------------------
package pidpos_pkg;

  localparam int SUM_WIDTH_DEF   = 32;
  localparam int COUNT_WIDTH_DEF = 10;

  localparam int GAIN_W  = 18;
  localparam int ZONE_W  = 15;
  localparam int BAND_W  = 10;
  localparam int DELAY_W = 10;
  localparam int CFG_W   = 18;
  localparam int CFG_IDX_W = 3;

  localparam int GOAL_W  = 15;
  localparam int SCALE_W = 16;
  localparam int POS_W   = 16;
  localparam int ERR_W   = 17;
  localparam int DRIVE_W = 15;

  // shared multiplier: chunk width equals the Q2.16 x Q8.8 fraction shift
  localparam int MUL_A_W    = 24;
  localparam int MUL_B_W    = 18;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int SUM_MAG_W  = 2 * MUL_A_W;
  localparam int TERM_LOG2  = 47;
  localparam int TOTAL_LOG2 = 46;
  localparam int ACC_W      = 50;
  localparam int TMAG_W     = TOTAL_LOG2 + 1;

  localparam logic [SUM_MAG_W-1:0] TERM_LIM  = SUM_MAG_W'(1) << TERM_LOG2;
  localparam logic [ACC_W-1:0]     TOTAL_LIM = ACC_W'(1) << TOTAL_LOG2;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 15'sd12000;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -15'sd12000;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST = 18'd32768;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST = 18'd1802;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST = 18'd72090;
  localparam logic [ZONE_W-1:0]  ZONE_RST   = 15'd100;
  localparam logic [BAND_W-1:0]  BAND_RST   = 10'd15;
  localparam logic [DELAY_W-1:0] DELAY_RST  = 10'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_GAIN_D  = 3'd2,
    REG_ZONE    = 3'd3,
    REG_BAND    = 3'd4,
    REG_DELAY   = 3'd5
  } pidpos_reg_t;

  typedef enum logic {
    MODE_START  = 1'b0,
    MODE_SAMPLE = 1'b1
  } pidpos_mode_t;

  typedef struct packed {
    logic                    mode;
    logic [GOAL_W-1:0]       target_angle;
    logic [SCALE_W-1:0]      gain_factor;
    logic                    hold_raised;
    logic signed [POS_W-1:0] position;
  } pidpos_in_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_mv;
    logic                      moving;
    logic                      done_res;
  } pidpos_out_t;

  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } pidpos_mul_op_t;

endpackage

// ===== rtl/pidpos_mul.sv =====
// ----------------------------------------------------------------------------
// pidpos_mul
// Shared unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
module pidpos_mul import pidpos_pkg::*; (
  input  logic                clk,
  input  pidpos_mul_op_t      op,
  output logic [PROD_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op.a) * PROD_W'(op.b);
  end

endmodule

// ===== rtl/pid_position_loop_with_settle_top.sv =====
// ----------------------------------------------------------------------------
// pid_position_loop_with_settle_top
// Position PID loop with integral zone and settle detection for one axis.
//
// Input channel (in_valid/in_ready/in_word): a start word (mode 0) loads the
// target and output scale unless the loop is busy or hold_raised is set; a
// sample word (mode 1) carries the encoder position. Every input word gives
// exactly one output word (out_valid/out_ready/out_word).
// Config port (cfg_write/cfg_index/cfg_data): the user writes it only while
// idle; the block itself does not enforce this. A sample word while busy
// passes through the multiplier states before out_valid; start words and idle
// samples go from ST_ERR straight to ST_OUT. The block takes one word at a
// time. The sample path is set by the single 24x18 multiplier, which is
// walked through the P, D, two integral and two output-scale products in turn.
// A finished result waits in the output register while the receiver stalls;
// the next word can be accepted meanwhile but is held before its result.
// Reset (synchronous, rst high) restores the default gains and leaves the
// loop idle with the settle detector armed.
// ----------------------------------------------------------------------------
module pid_position_loop_with_settle_top import pidpos_pkg::*; #(
  parameter int SUM_WIDTH   = SUM_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pidpos_in_t           in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pidpos_out_t          out_word,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

`include "assert_macros.svh"

  localparam int CMP_W = (COUNT_WIDTH > DELAY_W) ? COUNT_WIDTH : DELAY_W;

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_ERR  = 14'b00000000000010,
    ST_MAG  = 14'b00000000000100,
    ST_MP   = 14'b00000000001000,
    ST_MD   = 14'b00000000010000,
    ST_MIL  = 14'b00000000100000,
    ST_MIH  = 14'b00000001000000,
    ST_ICMB = 14'b00000010000000,
    ST_IADD = 14'b00000100000000,
    ST_CLMP = 14'b00001000000000,
    ST_SLO  = 14'b00010000000000,
    ST_SHI  = 14'b00100000000000,
    ST_FIN  = 14'b01000000000000,
    ST_OUT  = 14'b10000000000000
  } state_t;

  state_t state;

  // configuration
  logic [GAIN_W-1:0]  gain_p, gain_i, gain_d;
  logic [ZONE_W-1:0]  integral_zone;
  logic [BAND_W-1:0]  settle_band;
  logic [DELAY_W-1:0] exit_delay;

  // loop state
  logic [GOAL_W-1:0]      goal;
  logic [SCALE_W-1:0]     scale;
  logic [SUM_WIDTH-1:0]   error_sum;
  logic [ERR_W-1:0]       previous_error;
  logic                   busy, first_pass_pending, passed_once;
  logic [COUNT_WIDTH-1:0] elapsed;

  // per-word working registers
  pidpos_in_t          in_q;
  pidpos_out_t         res_q;
  logic                done_q;
  logic [ERR_W-1:0]    err_q;
  logic [ERR_W:0]      de_q;
  logic [POS_W-1:0]    err_mag, de_mag;
  logic                err_neg, de_neg, sum_neg;
  logic [SUM_WIDTH-1:0] sum_mag;
  logic [PROD_W-1:0]   i_lo;
  logic [SUM_MAG_W-1:0] i_mag;
  logic [ACC_W-1:0]    acc;
  logic [TMAG_W-1:0]   t_mag;
  logic                t_neg;
  logic [SCALE_W-1:0]  s_lo;

  pidpos_mul_op_t     mul_op;
  logic [PROD_W-1:0]  prod_q;

  pidpos_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod_q)
  );

  assign in_ready = (state == ST_IDLE);

  // ---------------- error, integral and settle update for one word ----------
  logic [ERR_W-1:0]       pos_ext, apos;
  logic [ERR_W:0]         err_full, low, high, apos_s;
  logic [ERR_W-1:0]       err;
  logic                   in_zone, above_low, below_high;
  logic [SUM_WIDTH:0]     sum_add;
  logic [SUM_WIDTH-1:0]   sum_next;
  logic [COUNT_WIDTH-1:0] e_inc, elapsed_next;
  logic                   delay_hit, done_next, busy_next, fpp_next, passed_next;
  logic                   start_ok, compute;

  always_comb begin
    pos_ext    = {in_q.position[POS_W-1], in_q.position};
    apos       = pos_ext[ERR_W-1] ? ERR_W'(-pos_ext) : pos_ext;
    apos_s     = {1'b0, apos};
    err_full   = {3'b000, goal} - apos_s;
    err        = err_full[ERR_W-1:0];
    low        = {3'b000, goal} - {8'b0, settle_band};
    high       = {3'b000, goal} + {8'b0, settle_band};
    above_low  = $signed(apos_s) > $signed(low);
    below_high = $signed(apos_s) < $signed(high);
    in_zone    = $signed(err_full) < $signed({3'b000, integral_zone});

    sum_add = {error_sum[SUM_WIDTH-1], error_sum}
            + {{(SUM_WIDTH-POS_W){err[ERR_W-1]}}, err};
    if (!in_zone) begin
      sum_next = '0;
    end else if (sum_add[SUM_WIDTH] != sum_add[SUM_WIDTH-1]) begin
      // clamp to the signed range
      sum_next = {sum_add[SUM_WIDTH], {(SUM_WIDTH-1){~sum_add[SUM_WIDTH]}}};
    end else begin
      sum_next = sum_add[SUM_WIDTH-1:0];
    end

    e_inc     = (elapsed != '1) ? elapsed + 1'b1 : elapsed;
    delay_hit = (CMP_W'(e_inc) >= CMP_W'(exit_delay)) || (e_inc == '1);

    start_ok     = (in_q.mode == MODE_START) && !busy && !in_q.hold_raised;
    compute      = (in_q.mode == MODE_SAMPLE) && busy;
    done_next    = 1'b0;
    fpp_next     = first_pass_pending;
    passed_next  = passed_once;
    elapsed_next = elapsed;
    if (passed_once) begin
      elapsed_next = e_inc;
      if (delay_hit) begin
        if (above_low && below_high) begin
          done_next = 1'b1;
        end else begin
          elapsed_next = '0;
        end
      end
    end else if (first_pass_pending && above_low) begin
      fpp_next     = 1'b0;
      passed_next  = 1'b1;
      elapsed_next = '0;
    end
    busy_next = !done_next;
  end

  // ---------------- shared multiplier operands ----------------
  logic [SUM_MAG_W-1:0] sum_mag_ext;
  assign sum_mag_ext = SUM_MAG_W'(sum_mag);

  always_comb begin
    mul_op = '0;
    unique case (state)
      ST_MP:   mul_op = '{a: MUL_A_W'(err_mag), b: gain_p};
      ST_MD:   mul_op = '{a: MUL_A_W'(de_mag), b: gain_d};
      ST_MIL:  mul_op = '{a: sum_mag_ext[MUL_A_W-1:0], b: gain_i};
      ST_MIH:  mul_op = '{a: sum_mag_ext[SUM_MAG_W-1:MUL_A_W], b: gain_i};
      ST_SLO:  mul_op = '{a: t_mag[MUL_A_W-1:0], b: MUL_B_W'(scale)};
      ST_SHI:  mul_op = '{a: MUL_A_W'(t_mag[TMAG_W-1:MUL_A_W]), b: MUL_B_W'(scale)};
      default: mul_op = '0;
    endcase
  end

  // ---------------- datapath arithmetic ----------------
  logic [ERR_W-1:0]     err_abs;
  logic [ERR_W:0]       de_abs;
  logic [ACC_W-1:0]     prod_ext, acc_abs;
  logic                 i_sat;
  logic [SUM_MAG_W-1:0] i_val;
  logic [PROD_W-1:0]    out_mag;
  logic [DRIVE_W-1:0]   drive_mag;
  logic [DRIVE_W-1:0]   drive_val;

  always_comb begin
    err_abs  = err_q[ERR_W-1] ? -err_q : err_q;
    de_abs   = de_q[ERR_W] ? -de_q : de_q;
    prod_ext = ACC_W'(prod_q);
    // the integral term saturates once the high chunk alone reaches 2^47
    i_sat    = |prod_q[PROD_W-1:TERM_LOG2-MUL_A_W];
    i_val    = SUM_MAG_W'({prod_q[TERM_LOG2-MUL_A_W-1:0], {MUL_A_W{1'b0}}})
             + SUM_MAG_W'(i_lo);
    acc_abs  = acc[ACC_W-1] ? -acc : acc;
    out_mag  = prod_q + PROD_W'(s_lo);
    drive_mag = (out_mag > PROD_W'(DRIVE_MAX)) ? DRIVE_MAX : out_mag[DRIVE_W-1:0];
    drive_val = t_neg ? -drive_mag : drive_mag;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          in_q <= in_word;
        end
      end
      ST_ERR: begin
        err_q <= err;
        de_q  <= {err[ERR_W-1], err} - {previous_error[ERR_W-1], previous_error};
      end
      ST_MAG: begin
        err_mag <= err_abs[POS_W-1:0];
        err_neg <= err_q[ERR_W-1];
        de_mag  <= de_abs[POS_W-1:0];
        de_neg  <= de_q[ERR_W];
        sum_mag <= error_sum[SUM_WIDTH-1] ? -error_sum : error_sum;
        sum_neg <= error_sum[SUM_WIDTH-1];
      end
      ST_MD:   acc <= err_neg ? -prod_ext : prod_ext;
      ST_MIL:  acc <= de_neg ? acc - prod_ext : acc + prod_ext;
      ST_MIH:  i_lo <= prod_q;
      ST_ICMB: i_mag <= (i_sat || i_val > TERM_LIM) ? TERM_LIM : i_val;
      ST_IADD: acc <= sum_neg ? acc - ACC_W'(i_mag) : acc + ACC_W'(i_mag);
      ST_CLMP: begin
        t_neg <= acc[ACC_W-1];
        t_mag <= (acc_abs > TOTAL_LIM) ? TOTAL_LIM[TMAG_W-1:0] : acc_abs[TMAG_W-1:0];
      end
      ST_SHI:  s_lo <= prod_q[MUL_A_W+SCALE_W-1:MUL_A_W];
      default: ;
    endcase
  end

  // ---------------- sequencer and loop state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      out_valid          <= 1'b0;
      gain_p             <= GAIN_P_RST;
      gain_i             <= GAIN_I_RST;
      gain_d             <= GAIN_D_RST;
      integral_zone      <= ZONE_RST;
      settle_band        <= BAND_RST;
      exit_delay         <= DELAY_RST;
      goal               <= '0;
      scale              <= '0;
      error_sum          <= '0;
      previous_error     <= '0;
      busy               <= 1'b0;
      first_pass_pending <= 1'b1;
      passed_once        <= 1'b0;
      elapsed            <= '0;
      done_q             <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_GAIN_P: gain_p        <= cfg_data;
          REG_GAIN_I: gain_i        <= cfg_data;
          REG_GAIN_D: gain_d        <= cfg_data;
          REG_ZONE:   integral_zone <= cfg_data[ZONE_W-1:0];
          REG_BAND:   settle_band   <= cfg_data[BAND_W-1:0];
          REG_DELAY:  exit_delay    <= cfg_data[DELAY_W-1:0];
          default: ;
        endcase
      end

      // a word is loaded in ST_OUT only once the register is free
      out_valid <= (state == ST_OUT) || (out_valid && !out_ready);

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_ERR;
          end
        end
        ST_ERR: begin
          if (compute) begin
            error_sum          <= sum_next;
            previous_error     <= err;
            first_pass_pending <= fpp_next;
            passed_once        <= passed_next;
            elapsed            <= elapsed_next;
            busy               <= busy_next;
            done_q             <= done_next;
            state              <= ST_MAG;
          end else begin
            if (start_ok) begin
              goal               <= in_q.target_angle;
              scale              <= in_q.gain_factor;
              error_sum          <= '0;
              previous_error     <= '0;
              first_pass_pending <= 1'b1;
              passed_once        <= 1'b0;
              elapsed            <= '0;
              busy               <= 1'b1;
            end
            res_q <= '{drive_mv: '0, moving: busy || start_ok, done_res: 1'b0};
            state <= ST_OUT;
          end
        end
        ST_MAG:  state <= ST_MP;
        ST_MP:   state <= ST_MD;
        ST_MD:   state <= ST_MIL;
        ST_MIL:  state <= ST_MIH;
        ST_MIH:  state <= ST_ICMB;
        ST_ICMB: state <= ST_IADD;
        ST_IADD: state <= ST_CLMP;
        ST_CLMP: state <= ST_SLO;
        ST_SLO:  state <= ST_SHI;
        ST_SHI:  state <= ST_FIN;
        ST_FIN: begin
          // the settling word carries the final stop command
          res_q <= '{drive_mv: done_q ? '0 : drive_val, moving: busy, done_res: done_q};
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_word  <= res_q;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------- checks ----------------
  `ASSERT_HOLDS(a_done_stops, out_valid && out_word.done_res, !out_word.moving && out_word.drive_mv == '0)
  `ASSERT_HOLDS(a_drive_range, out_valid, out_word.drive_mv <= DRIVE_MAX && out_word.drive_mv >= DRIVE_MIN)
  `ASSERT_HOLDS(a_settle_flags, passed_once, !first_pass_pending)
  `ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready)

endmodule
